// ===== rtl/bitmap_page_frame_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// bitmap page frame allocator assertion macros
// concurrent assertion shorthands shared by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPFA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPFA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bpfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_pkg
// shared constants, types and helper functions of the page frame allocator
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int ADDR_BITS  = 32;
    localparam int PAGE_BITS  = 12;
    localparam int FRAME_BITS = ADDR_BITS - PAGE_BITS;
    localparam int FIDX_W     = FRAME_BITS + 1;

    localparam int WORD_BITS  = 32;
    localparam int BIT_IDX_W  = 5;
    localparam int WCNT_W     = BIT_IDX_W + 1;
    localparam int WADDR_W    = FRAME_BITS - BIT_IDX_W;
    localparam int WORD_COUNT = 2 ** WADDR_W;

    localparam int OP_W    = 3;
    localparam int BASE_W  = 32;
    localparam int LEN_W   = 33;
    localparam int KIND_W  = 32;
    localparam int FADDR_W = 32;
    localparam int CNT_W   = 33;
    localparam int SUM_W   = 34;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_SEL_LSB = 2;

    localparam logic [0:0] REG_KERNEL_IMAGE_END = 1'b0;

    localparam logic [SUM_W-1:0]     FRAME_COUNT    = SUM_W'(1) << FRAME_BITS;
    localparam logic [SUM_W-1:0]     PAGE_MASK      = (SUM_W'(1) << PAGE_BITS) - SUM_W'(1);
    localparam logic [CNT_W-1:0]     CNT_MAX        = '1;
    localparam logic [WORD_BITS-1:0] WORD_FULL      = '1;
    localparam logic [KIND_W-1:0]    KIND_AVAILABLE = KIND_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR          = 3'd0,
        OP_ADD_REGION     = 3'd1,
        OP_RESERVE_KERNEL = 3'd2,
        OP_RESERVE_RANGE  = 3'd3,
        OP_ALLOCATE       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        WU_FREE,
        WU_RESERVE,
        WU_FIND
    } wu_mode_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_PREP,
        ST_RANGE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        wu_mode_t              mode;
        logic [WADDR_W-1:0]    word_idx;
        logic [FRAME_BITS-1:0] first_frame;
        logic [FRAME_BITS-1:0] last_frame;
    } wu_ctrl_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] new_word;
        logic [WCNT_W-1:0]    count;
        logic                 found;
        logic [BIT_IDX_W-1:0] bit_idx;
    } wu_result_t;

    function automatic logic [FIDX_W-1:0] clip_frame(input logic [SUM_W-1:0] x);
        if (x > FRAME_COUNT) begin
            return FRAME_COUNT[FIDX_W-1:0];
        end
        return x[FIDX_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] page_delta(input logic [WCNT_W-1:0] n);
        return CNT_W'({n, {PAGE_BITS{1'b0}}});
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] d);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, d};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] d);
        return (a > d) ? (a - d) : '0;
    endfunction

endpackage

// ===== rtl/bpfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/bpfa_word_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_word_unit
// shared bitmap word unit: range mask, free/reserve update, first free search
// ----------------------------------------------------------------------------
module bpfa_word_unit (
    input  bpfa_pkg::wu_ctrl_t                   ctrl,
    input  logic [bpfa_pkg::WORD_BITS-1:0]       word,
    output bpfa_pkg::wu_result_t                 res
);

    import bpfa_pkg::*;

    logic [BIT_IDX_W-1:0] lo_bit;
    logic [BIT_IDX_W-1:0] hi_bit;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] hit;
    logic [BIT_IDX_W-1:0] zero_idx;
    logic                 has_zero;

    function automatic logic [WCNT_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
        logic [WCNT_W-1:0] total;
        logic [3:0]        part;
        total = '0;
        for (int g = 0; g < WORD_BITS / 8; g++) begin
            part = '0;
            for (int b = 0; b < 8; b++) begin
                part = part + 4'(v[g*8+b]);
            end
            total = total + WCNT_W'(part);
        end
        return total;
    endfunction

    always_comb begin
        lo_bit = (ctrl.word_idx == ctrl.first_frame[FRAME_BITS-1:BIT_IDX_W]) ?
                 ctrl.first_frame[BIT_IDX_W-1:0] : '0;
        hi_bit = (ctrl.word_idx == ctrl.last_frame[FRAME_BITS-1:BIT_IDX_W]) ?
                 ctrl.last_frame[BIT_IDX_W-1:0] : '1;
        mask   = (WORD_FULL << lo_bit) & (WORD_FULL >> (~hi_bit));

        // lowest clear bit
        has_zero = (word != WORD_FULL);
        zero_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                zero_idx = BIT_IDX_W'(i);
            end
        end

        unique case (ctrl.mode)
            WU_FREE: begin
                hit          = mask;
                res.new_word = word & ~mask;
            end
            WU_RESERVE: begin
                hit          = mask & ~word;
                res.new_word = word | mask;
            end
            WU_FIND: begin
                hit          = has_zero ? (WORD_BITS'(1) << zero_idx) : '0;
                res.new_word = word | hit;
            end
            default: begin
                hit          = '0;
                res.new_word = word;
            end
        endcase

        res.count   = popcount(hit);
        res.found   = has_zero;
        res.bit_idx = zero_idx;
    end

endmodule

// ===== rtl/bitmap_page_frame_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// used/free bitmap of page frames with system and free byte counters
// ----------------------------------------------------------------------------
// s_ channel takes one operation per transfer: clear, add available region,
// reserve kernel image, reserve range, allocate. m_ channel returns exactly
// one result per operation with the allocated address, a fail flag and both
// byte counters after the operation. kernel_image_end sits at apb address 0.
// the bitmap lives in a ram of 32768 words of 32 frames; one word unit reads,
// updates and writes one word at a time, and that ram port sets the rate.
// region and reserve operations read and write each bitmap word that they
// touch (a region of another kind touches none), allocate scans words from
// the first until it finds a free frame or reaches the last, clear sweeps the
// whole ram and other codes touch no word. s_ready is high only while no
// operation is in flight.
// after reset the block sweeps the ram to all-used with s_ready low; apb
// writes are taken throughout. results sit in an output register, so a
// stalled m_ready does not stop the next s_ transfer; the following result
// waits until the held one is taken.
// ----------------------------------------------------------------------------
`include "bitmap_page_frame_allocator_assert.svh"

module bitmap_page_frame_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bpfa_pkg::OP_W-1:0]     s_operation,
    input  logic [bpfa_pkg::BASE_W-1:0]   s_region_base,
    input  logic [bpfa_pkg::LEN_W-1:0]    s_region_length,
    input  logic [bpfa_pkg::KIND_W-1:0]   s_region_kind,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bpfa_pkg::FADDR_W-1:0]  m_frame_address,
    output logic                          m_alloc_failed,
    output logic [bpfa_pkg::CNT_W-1:0]    m_free_bytes,
    output logic [bpfa_pkg::CNT_W-1:0]    m_system_bytes,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfa_pkg::APB_AW-1:0]   paddr,
    input  logic [bpfa_pkg::APB_DW-1:0]   pwdata,
    output logic [bpfa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    import bpfa_pkg::*;

    state_t                state_reg, state_next;
    wu_mode_t              mode_reg, mode_next;
    logic                  reply_reg, reply_next;
    logic [WADDR_W-1:0]    w_reg, w_next;
    logic [WADDR_W-1:0]    last_word_reg, last_word_next;
    logic [FIDX_W-1:0]     first_reg, first_next;
    logic [FIDX_W-1:0]     end_reg, end_next;
    logic [FRAME_BITS-1:0] last_frame_reg, last_frame_next;

    logic [OP_W-1:0]       op_reg, op_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;

    logic [FADDR_W-1:0]    addr_reg, addr_next;
    logic                  fail_reg, fail_next;
    logic [CNT_W-1:0]      free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]      sys_cnt_reg, sys_cnt_next;
    logic [BASE_W-1:0]     kie_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [FADDR_W-1:0]    m_addr_reg, m_addr_next;
    logic                  m_fail_reg, m_fail_next;
    logic [CNT_W-1:0]      m_free_reg, m_free_next;
    logic [CNT_W-1:0]      m_sys_reg, m_sys_next;

    logic                  ram_we;
    logic                  ram_re;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;

    wu_ctrl_t              wu_ctrl;
    wu_result_t            wu_res;

    logic [SUM_W-1:0]      end_sum;
    logic [SUM_W-1:0]      first_up;
    logic [FIDX_W-1:0]     end_m1;
    logic [CNT_W-1:0]      delta;
    logic                  apb_wr;

    // configuration port
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kie_reg <= '0;
        end else if (apb_wr && (paddr[APB_AW-1:REG_SEL_LSB] == REG_KERNEL_IMAGE_END)) begin
            kie_reg <= pwdata;
        end
    end

    always_comb begin
        prdata = (paddr[APB_AW-1:REG_SEL_LSB] == REG_KERNEL_IMAGE_END) ? kie_reg : '0;
    end

    // bitmap store and word unit
    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_map (
        .clk   (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (w_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign wu_ctrl.mode        = mode_reg;
    assign wu_ctrl.word_idx    = w_reg;
    assign wu_ctrl.first_frame = first_reg[FRAME_BITS-1:0];
    assign wu_ctrl.last_frame  = last_frame_reg;

    bpfa_word_unit u_word (
        .ctrl (wu_ctrl),
        .word (ram_rdata),
        .res  (wu_res)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_frame_address = m_addr_reg;
    assign m_alloc_failed  = m_fail_reg;
    assign m_free_bytes    = m_free_reg;
    assign m_system_bytes  = m_sys_reg;

    assign end_sum  = SUM_W'(base_reg) + SUM_W'(len_reg) + PAGE_MASK;
    assign first_up = SUM_W'(base_reg) + PAGE_MASK;
    assign end_m1   = end_reg - FIDX_W'(1);
    assign delta    = page_delta(wu_res.count);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        reply_next      = reply_reg;
        w_next          = w_reg;
        last_word_next  = last_word_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        last_frame_next = last_frame_reg;
        op_next         = op_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        fail_next       = fail_reg;
        free_cnt_next   = free_cnt_reg;
        sys_cnt_next    = sys_cnt_reg;
        m_valid_next    = m_valid_reg;
        m_addr_next     = m_addr_reg;
        m_fail_next     = m_fail_reg;
        m_free_next     = m_free_reg;
        m_sys_next      = m_sys_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_wdata       = wu_res.new_word;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_wdata = WORD_FULL;
                if (w_reg == '1) begin
                    w_next     = '0;
                    state_next = reply_reg ? ST_FINISH : ST_IDLE;
                end else begin
                    w_next = w_reg + WADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    base_next  = s_region_base;
                    len_next   = s_region_length;
                    kind_next  = s_region_kind;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                addr_next = '0;
                fail_next = 1'b0;
                unique case (op_reg)
                    OP_CLEAR: begin
                        free_cnt_next = '0;
                        sys_cnt_next  = '0;
                        reply_next    = 1'b1;
                        w_next        = '0;
                        state_next    = ST_SWEEP;
                    end
                    OP_ADD_REGION: begin
                        if (kind_reg == KIND_AVAILABLE) begin
                            first_next = clip_frame(first_up >> PAGE_BITS);
                            end_next   = clip_frame(end_sum >> PAGE_BITS);
                            mode_next  = WU_FREE;
                            state_next = ST_RANGE;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                    OP_RESERVE_KERNEL: begin
                        first_next = '0;
                        end_next   = clip_frame(SUM_W'(kie_reg >> PAGE_BITS));
                        mode_next  = WU_RESERVE;
                        state_next = ST_RANGE;
                    end
                    OP_RESERVE_RANGE: begin
                        first_next = clip_frame(SUM_W'(base_reg >> PAGE_BITS));
                        end_next   = clip_frame(end_sum >> PAGE_BITS);
                        mode_next  = WU_RESERVE;
                        state_next = ST_RANGE;
                    end
                    OP_ALLOCATE: begin
                        w_next         = '0;
                        last_word_next = '1;
                        mode_next      = WU_FIND;
                        state_next     = ST_READ;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_RANGE: begin
                if (first_reg >= end_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    w_next          = first_reg[FRAME_BITS-1:BIT_IDX_W];
                    last_word_next  = end_m1[FRAME_BITS-1:BIT_IDX_W];
                    last_frame_next = end_m1[FRAME_BITS-1:0];
                    state_next      = ST_READ;
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                ram_we = 1'b1;
                if (mode_reg == WU_FREE) begin
                    sys_cnt_next  = sat_add(sys_cnt_reg, delta);
                    free_cnt_next = sat_add(free_cnt_reg, delta);
                end else begin
                    free_cnt_next = sat_sub(free_cnt_reg, delta);
                end
                priority if ((mode_reg == WU_FIND) && wu_res.found) begin
                    addr_next  = FADDR_W'({w_reg, wu_res.bit_idx, {PAGE_BITS{1'b0}}});
                    state_next = ST_FINISH;
                end else if (w_reg == last_word_reg) begin
                    fail_next  = (mode_reg == WU_FIND);
                    state_next = ST_FINISH;
                end else begin
                    w_next     = w_reg + WADDR_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = addr_reg;
                    m_fail_next  = fail_reg;
                    m_free_next  = free_cnt_reg;
                    m_sys_next   = sys_cnt_reg;
                    reply_next   = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= WU_FREE;
            reply_reg    <= 1'b0;
            w_reg        <= '0;
            free_cnt_reg <= '0;
            sys_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            reply_reg    <= reply_next;
            w_reg        <= w_next;
            free_cnt_reg <= free_cnt_next;
            sys_cnt_reg  <= sys_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_word_reg  <= last_word_next;
        first_reg      <= first_next;
        end_reg        <= end_next;
        last_frame_reg <= last_frame_next;
        op_reg         <= op_next;
        base_reg       <= base_next;
        len_reg        <= len_next;
        kind_reg       <= kind_next;
        addr_reg       <= addr_next;
        fail_reg       <= fail_next;
        m_addr_reg     <= m_addr_next;
        m_fail_reg     <= m_fail_next;
        m_free_reg     <= m_free_next;
        m_sys_reg      <= m_sys_next;
    end

    `BPFA_ASSERT_IMP(a_free_le_system, aclk, aresetn, 1'b1, free_cnt_reg <= sys_cnt_reg,
        "free byte count exceeds system byte count")
    `BPFA_ASSERT_NXT(a_accept_to_prep, aclk, aresetn, s_valid && s_ready,
        state_reg == ST_PREP, "accepted transfer did not start an operation")
    `BPFA_ASSERT_IMP(a_fail_no_addr, aclk, aresetn, m_valid && m_alloc_failed,
        m_frame_address == '0, "failed allocation carries an address")
    `BPFA_ASSERT_IMP(a_write_states, aclk, aresetn, ram_we,
        state_reg == ST_SWEEP || state_reg == ST_CHECK, "bitmap write outside update states")

endmodule
